@@ hw/rtl/scr_pkg.sv @@
// ----------------------------------------------------------------------------
// Shape coverage rasteriser package
// Shared register layout, shape codes and width helpers.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int unsigned IdxW     = 4;
  localparam int unsigned CountW   = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam int HrPix     = 24;
  localparam int HalfHrPix = 12;

  // Upper bound on a sample's distance from the centre, per unit of pool factor.
  localparam int unsigned DiffSpan = 1420;
  localparam int unsigned SizeMax  = 255;

  typedef enum logic [1:0] {
    SHAPE_CIRCLE   = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2
  } shape_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHAPE_KIND      = 3'd0,
    REG_CENTER_X        = 3'd1,
    REG_CENTER_Y        = 3'd2,
    REG_RADIUS          = 3'd3,
    REG_HALF_SIDE       = 3'd4,
    REG_TRI_HALF_BASE   = 3'd5,
    REG_TRI_HALF_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         shape_kind;
    logic signed [10:0] center_x;
    logic signed [10:0] center_y;
    logic [7:0]         radius;
    logic [7:0]         half_side;
    logic [7:0]         tri_half_base;
    logic [7:0]         tri_half_height;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    shape_kind:      2'd0,
    center_x:        11'sd192,
    center_y:        11'sd192,
    radius:          8'd96,
    half_side:       8'd96,
    tri_half_base:   8'd96,
    tri_half_height: 8'd96
  };

  function automatic int unsigned diff_w(input int unsigned pf);
    return $clog2(DiffSpan * pf) + 1;
  endfunction

  function automatic int unsigned scaled_w(input int unsigned pf);
    return $clog2(SizeMax * pf + 1);
  endfunction

  // Offset of sample position k along one axis from the output pixel origin.
  function automatic int sub_offset(input int pf, input int k);
    return HrPix * (k >> 1) + HalfHrPix + (((k & 1) != 0) ? 6 * pf : -2 * pf);
  endfunction

endpackage

@@ hw/rtl/scr_coord.sv @@
// ----------------------------------------------------------------------------
// Sample coordinate stage
// Wraps the pixel index and forms every sample offset from the shape centre.
// ----------------------------------------------------------------------------
module scr_coord #(
  parameter int unsigned OUT_SIZE    = 16,
  parameter int unsigned POOL_FACTOR = 4,
  localparam int unsigned N  = 2 * POOL_FACTOR,
  localparam int unsigned DW = scr_pkg::diff_w(POOL_FACTOR)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  scr_pkg::cfg_t               cfg_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [scr_pkg::IdxW-1:0]    out_x_i,
  input  logic [scr_pkg::IdxW-1:0]    out_y_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [N-1:0][DW-1:0]        dx_o,
  output logic [N-1:0][DW-1:0]        dy_o
);
  import scr_pkg::*;

  typedef logic [IdxW-1:0] idx_tbl_t [2**IdxW];

  function automatic idx_tbl_t build_wrap_tbl();
    idx_tbl_t t;
    for (int v = 0; v < 2**IdxW; v++) begin
      t[v] = IdxW'(v % OUT_SIZE);
    end
    return t;
  endfunction

  localparam idx_tbl_t WrapTbl = build_wrap_tbl();
  localparam int unsigned Pitch = HrPix * POOL_FACTOR;

  logic [DW-1:0]         cx_s, cy_s, base_x, base_y;
  logic [N-1:0][DW-1:0]  dx_d, dy_d, dx_q, dy_q;
  logic                  valid_q;

  assign cx_s   = DW'($signed(cfg_i.center_x)) * DW'(POOL_FACTOR);
  assign cy_s   = DW'($signed(cfg_i.center_y)) * DW'(POOL_FACTOR);
  assign base_x = DW'(WrapTbl[out_x_i]) * DW'(Pitch) - cx_s;
  assign base_y = DW'(WrapTbl[out_y_i]) * DW'(Pitch) - cy_s;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      dx_d[k] = base_x + DW'(sub_offset(POOL_FACTOR, k));
      dy_d[k] = base_y + DW'(sub_offset(POOL_FACTOR, k));
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign valid_o = valid_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;

endmodule

@@ hw/rtl/scr_prod.sv @@
// ----------------------------------------------------------------------------
// Product stage
// Squares, edge products and per-axis box tests for every column and row.
// ----------------------------------------------------------------------------
module scr_prod #(
  parameter int unsigned POOL_FACTOR = 4,
  localparam int unsigned N   = 2 * POOL_FACTOR,
  localparam int unsigned DW  = scr_pkg::diff_w(POOL_FACTOR),
  localparam int unsigned HW  = scr_pkg::scaled_w(POOL_FACTOR),
  localparam int unsigned SqW = 2 * (DW - 1),
  localparam int unsigned PW  = HW + DW + 1,
  localparam int unsigned R2W = 2 * HW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [N-1:0][DW-1:0]  dx_i,
  input  logic [N-1:0][DW-1:0]  dy_i,
  input  logic [HW-1:0]         hs_s_i,
  input  logic [HW-1:0]         hb_s_i,
  input  logic [HW-1:0]         hh_s_i,
  input  logic [R2W-1:0]        hbhh_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [N-1:0][SqW-1:0] sqx_o,
  output logic [N-1:0][SqW-1:0] sqy_o,
  output logic [N-1:0][PW-1:0]  ax_o,
  output logic [N-1:0][PW-1:0]  by_o,
  output logic [N-1:0]          okx_o,
  output logic [N-1:0]          oky_o,
  output logic [N-1:0]          s2n_o,
  output logic [N-1:0]          s2p_o
);
  import scr_pkg::*;

  logic [N-1:0][SqW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic [N-1:0][PW-1:0]  ax_d, by_d, ax_q, by_q;
  logic [N-1:0]          okx_d, oky_d, s2n_d, s2p_d;
  logic [N-1:0]          okx_q, oky_q, s2n_q, s2p_q;
  logic signed [DW-1:0]  hs_x, hh_x;
  logic                  valid_q;

  assign hs_x = $signed(DW'(hs_s_i));
  assign hh_x = $signed(DW'(hh_s_i));

  always_comb begin
    for (int k = 0; k < N; k++) begin
      sqx_d[k] = SqW'($signed(dx_i[k]) * $signed(dx_i[k]));
      sqy_d[k] = SqW'($signed(dy_i[k]) * $signed(dy_i[k]));
      ax_d[k]  = {(PW-1)'($signed({1'b0, hh_s_i}) * $signed(dx_i[k])), 1'b0};
      by_d[k]  = PW'($signed({1'b0, hb_s_i}) * $signed(dy_i[k])) + PW'(hbhh_i);
      okx_d[k] = ($signed(dx_i[k]) <= hs_x) && ($signed(dx_i[k]) >= -hs_x);
      oky_d[k] = ($signed(dy_i[k]) <= hs_x) && ($signed(dy_i[k]) >= -hs_x);
      s2n_d[k] = (hb_s_i != '0) && ($signed(dy_i[k]) < hh_x);
      s2p_d[k] = (hb_s_i != '0) && ($signed(dy_i[k]) > hh_x);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      ax_q  <= ax_d;
      by_q  <= by_d;
      okx_q <= okx_d;
      oky_q <= oky_d;
      s2n_q <= s2n_d;
      s2p_q <= s2p_d;
    end
  end

  assign valid_o = valid_q;
  assign sqx_o   = sqx_q;
  assign sqy_o   = sqy_q;
  assign ax_o    = ax_q;
  assign by_o    = by_q;
  assign okx_o   = okx_q;
  assign oky_o   = oky_q;
  assign s2n_o   = s2n_q;
  assign s2p_o   = s2p_q;

endmodule

@@ hw/rtl/scr_test.sv @@
// ----------------------------------------------------------------------------
// Sample test stage
// Combines column and row terms into one inside bit per sample.
// ----------------------------------------------------------------------------
module scr_test #(
  parameter int unsigned POOL_FACTOR = 4,
  localparam int unsigned N   = 2 * POOL_FACTOR,
  localparam int unsigned DW  = scr_pkg::diff_w(POOL_FACTOR),
  localparam int unsigned HW  = scr_pkg::scaled_w(POOL_FACTOR),
  localparam int unsigned SqW = 2 * (DW - 1),
  localparam int unsigned PW  = HW + DW + 1,
  localparam int unsigned R2W = 2 * HW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scr_pkg::cfg_t         cfg_i,
  input  logic [R2W-1:0]        r2_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [N-1:0][SqW-1:0] sqx_i,
  input  logic [N-1:0][SqW-1:0] sqy_i,
  input  logic [N-1:0][PW-1:0]  ax_i,
  input  logic [N-1:0][PW-1:0]  by_i,
  input  logic [N-1:0]          okx_i,
  input  logic [N-1:0]          oky_i,
  input  logic [N-1:0]          s2n_i,
  input  logic [N-1:0]          s2p_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [N-1:0][N-1:0]   inside_o
);
  import scr_pkg::*;

  logic [N-1:0][N-1:0] inside_d, inside_q;
  logic                valid_q;

  always_comb begin
    logic [SqW:0]        sum_sq;
    logic signed [PW:0]  t_sum;
    logic signed [PW:0]  t_dif;
    logic                circ;
    logic                neg;
    logic                pos;
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        sum_sq = (SqW+1)'(sqx_i[c]) + (SqW+1)'(sqy_i[r]);
        circ   = sum_sq <= (SqW+1)'(r2_i);
        t_sum  = (PW+1)'($signed(ax_i[c])) + (PW+1)'($signed(by_i[r]));
        t_dif  = (PW+1)'($signed(ax_i[c])) - (PW+1)'($signed(by_i[r]));
        neg    = (t_sum > 0) || s2n_i[r] || (t_dif < 0);
        pos    = (t_sum < 0) || s2p_i[r] || (t_dif > 0);
        unique case (cfg_i.shape_kind)
          SHAPE_CIRCLE:   inside_d[r][c] = circ;
          SHAPE_SQUARE:   inside_d[r][c] = okx_i[c] && oky_i[r];
          SHAPE_TRIANGLE: inside_d[r][c] = !(neg && pos);
          default:        inside_d[r][c] = 1'b0;
        endcase
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      inside_q <= inside_d;
    end
  end

  assign valid_o  = valid_q;
  assign inside_o = inside_q;

endmodule

@@ hw/rtl/scr_count.sv @@
// ----------------------------------------------------------------------------
// Coverage count stages
// Counts inside bits per row, then sums the rows into the output register.
// ----------------------------------------------------------------------------
module scr_count #(
  parameter int unsigned POOL_FACTOR = 4,
  localparam int unsigned N = 2 * POOL_FACTOR
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [N-1:0][N-1:0]          inside_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [scr_pkg::CountW-1:0]   count_o
);
  import scr_pkg::*;

  localparam int unsigned RowW = $clog2(N + 1);
  localparam int unsigned TotW = $clog2(N * N + 1);

  logic [N-1:0][RowW-1:0] row_d, row_q;
  logic [TotW-1:0]        total;
  logic [CountW-1:0]      count_q;
  logic                   va_q, vb_q, ready_b;

  always_comb begin
    for (int r = 0; r < N; r++) begin
      row_d[r] = RowW'($countones(inside_i[r]));
    end
  end

  always_comb begin
    total = '0;
    for (int r = 0; r < N; r++) begin
      total = total + TotW'(row_q[r]);
    end
  end

  assign ready_b = !vb_q || ready_i;
  assign ready_o = !va_q || ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_o) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      row_q <= row_d;
    end
    if (va_q && ready_b) begin
      count_q <= CountW'(total);
    end
  end

  assign valid_o = vb_q;
  assign count_o = count_q;

endmodule

@@ hw/rtl/shape_coverage_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// Shape coverage rasteriser
// Counts the supersamples of one output pixel that fall inside a circle, a
// square or an upward triangle.
//
//   Channel   Direction  Beat contents
//   s_axis    in         out_x, out_y of the pixel to evaluate
//   m_axis    out        inside_count of that pixel
//   cfg       in         one register write per cycle, no read-back
//
// One beat is accepted every cycle while the output is not stalled; the result
// beat passes five register stages: coordinates,
// products, sample tests, row counts and the final sum.
// Reset clears the valid bits and loads the register defaults.
// A stalled output holds its beat; each stage fills while the one after it
// has room, so bubbles close up and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module shape_coverage_rasterizer_unit #(
  parameter int unsigned OUT_SIZE    = 16,
  parameter int unsigned POOL_FACTOR = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [scr_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // out_x [3:0], out_y [7:4]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata    // inside_count [6:0], zero [7]
);
  import scr_pkg::*;

  localparam int unsigned N         = 2 * POOL_FACTOR;
  localparam int unsigned DW        = diff_w(POOL_FACTOR);
  localparam int unsigned HW        = scaled_w(POOL_FACTOR);
  localparam int unsigned SqW       = 2 * (DW - 1);
  localparam int unsigned PW        = HW + DW + 1;
  localparam int unsigned R2W       = 2 * HW;
  localparam int unsigned PipeDepth = 5;
  localparam int unsigned OccW      = $clog2(PipeDepth + 1);

  cfg_t                  cfg_q;
  logic [HW-1:0]         rad_s, hs_s, hb_s, hh_s;
  logic [R2W-1:0]        r2_q, hbhh_q;

  logic                  c_valid, c_ready;
  logic [N-1:0][DW-1:0]  dx, dy;
  logic                  p_valid, p_ready;
  logic [N-1:0][SqW-1:0] sqx, sqy;
  logic [N-1:0][PW-1:0]  ax, by;
  logic [N-1:0]          okx, oky, s2n, s2p;
  logic                  t_valid, t_ready;
  logic [N-1:0][N-1:0]   hit_map;
  logic [CountW-1:0]     count;
  logic [OccW-1:0]       occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SHAPE_KIND:      cfg_q.shape_kind      <= cfg_wdata_i[1:0];
        REG_CENTER_X:        cfg_q.center_x        <= cfg_wdata_i;
        REG_CENTER_Y:        cfg_q.center_y        <= cfg_wdata_i;
        REG_RADIUS:          cfg_q.radius          <= cfg_wdata_i[7:0];
        REG_HALF_SIDE:       cfg_q.half_side       <= cfg_wdata_i[7:0];
        REG_TRI_HALF_BASE:   cfg_q.tri_half_base   <= cfg_wdata_i[7:0];
        REG_TRI_HALF_HEIGHT: cfg_q.tri_half_height <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign rad_s = HW'(cfg_q.radius)          * HW'(POOL_FACTOR);
  assign hs_s  = HW'(cfg_q.half_side)       * HW'(POOL_FACTOR);
  assign hb_s  = HW'(cfg_q.tri_half_base)   * HW'(POOL_FACTOR);
  assign hh_s  = HW'(cfg_q.tri_half_height) * HW'(POOL_FACTOR);

  // Register-derived products, refreshed every cycle from the settled registers.
  always_ff @(posedge clk_i) begin
    r2_q   <= R2W'(rad_s) * R2W'(rad_s);
    hbhh_q <= R2W'(hb_s) * R2W'(hh_s);
  end

  scr_coord #(
    .OUT_SIZE    (OUT_SIZE),
    .POOL_FACTOR (POOL_FACTOR)
  ) u_coord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .out_x_i (s_axis_tdata[3:0]),
    .out_y_i (s_axis_tdata[7:4]),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .dx_o    (dx),
    .dy_o    (dy)
  );

  scr_prod #(
    .POOL_FACTOR (POOL_FACTOR)
  ) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .dx_i    (dx),
    .dy_i    (dy),
    .hs_s_i  (hs_s),
    .hb_s_i  (hb_s),
    .hh_s_i  (hh_s),
    .hbhh_i  (hbhh_q),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .sqx_o   (sqx),
    .sqy_o   (sqy),
    .ax_o    (ax),
    .by_o    (by),
    .okx_o   (okx),
    .oky_o   (oky),
    .s2n_o   (s2n),
    .s2p_o   (s2p)
  );

  scr_test #(
    .POOL_FACTOR (POOL_FACTOR)
  ) u_test (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .r2_i     (r2_q),
    .valid_i  (p_valid),
    .ready_o  (p_ready),
    .sqx_i    (sqx),
    .sqy_i    (sqy),
    .ax_i     (ax),
    .by_i     (by),
    .okx_i    (okx),
    .oky_i    (oky),
    .s2n_i    (s2n),
    .s2p_i    (s2p),
    .valid_o  (t_valid),
    .ready_i  (t_ready),
    .inside_o (hit_map)
  );

  scr_count #(
    .POOL_FACTOR (POOL_FACTOR)
  ) u_count (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (t_valid),
    .ready_o  (t_ready),
    .inside_i (hit_map),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .count_o  (count)
  );

  assign m_axis_tdata = {1'b0, count};

  // Number of pixels in flight, kept for the checks below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OccW'(s_axis_tvalid && s_axis_tready)
                     - OccW'(m_axis_tvalid && m_axis_tready);
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(PipeDepth))
    else $error("More pixels in flight than pipeline stages.");

  a_out_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (occ_q != '0))
    else $error("Output beat shown with no pixel in flight.");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_q == OccW'(PipeDepth)) && !m_axis_tready) |-> !s_axis_tready)
    else $error("Input accepted while every stage is full and stalled.");

endmodule

@@ tb/shape_coverage_rasterizer_unit_test.sv @@
// ----------------------------------------------------------------------------
// Shape coverage rasteriser testbench
// Sends output pixel coordinates to the rasteriser under a series of shape
// settings. A local count of the supersamples that fall inside the shape
// predicts each result beat. Results are compared in order of arrival. Both
// stream sides stall at random, and the output is held off once for a long
// stretch so that the pipeline fills up.
// ----------------------------------------------------------------------------
module shape_coverage_rasterizer_unit_test;
  import scr_pkg::*;

  localparam int Pool    = 4;
  localparam int SubOffA = -2 * Pool;
  localparam int SubOffB = 6 * Pool;

  localparam logic [1:0]         ShapeUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused   = 3'd7;

  localparam int unsigned LongHold     = 80;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned PhaseCount   = 16;
  localparam int unsigned PhaseItems   = 100;

  typedef struct packed {
    logic [3:0] out_y;
    logic [3:0] out_x;
  } pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // out_x [3:0], out_y [7:4]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // inside_count [6:0], zero [7]

  cfg_t             cfg_model;
  logic [CountW-1:0] expected_counts[$];
  int unsigned      mismatch_count;
  bit               no_gaps;
  bit               hold_off_req;

  shape_coverage_rasterizer_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint edge_value(longint px, longint py, longint ax, longint ay,
                                        longint bx, longint by);
    return (px - bx) * (ay - by) - (ax - bx) * (py - by);
  endfunction

  function automatic logic [CountW-1:0] predict_coverage(cfg_t c, pixel_t p);
    longint cx, cy, r, hs, hb, hh, sx, sy, dx, dy, e1, e2, e3;
    bit hit, neg, pos;
    int unsigned hits;
    hits = 0;
    cx = longint'($signed(c.center_x)) * Pool;
    cy = longint'($signed(c.center_y)) * Pool;
    r  = longint'(c.radius) * Pool;
    hs = longint'(c.half_side) * Pool;
    hb = longint'(c.tri_half_base) * Pool;
    hh = longint'(c.tri_half_height) * Pool;
    for (int j = 0; j < 2 * Pool; j++) begin
      sy = (longint'(p.out_y) * Pool + j / 2) * HrPix + HalfHrPix
           + ((j % 2) != 0 ? SubOffB : SubOffA);
      for (int i = 0; i < 2 * Pool; i++) begin
        sx = (longint'(p.out_x) * Pool + i / 2) * HrPix + HalfHrPix
             + ((i % 2) != 0 ? SubOffB : SubOffA);
        dx = sx - cx;
        dy = sy - cy;
        case (c.shape_kind)
          SHAPE_CIRCLE:   hit = (dx * dx + dy * dy) <= r * r;
          SHAPE_SQUARE:   hit = (dx < 0 ? -dx : dx) <= hs && (dy < 0 ? -dy : dy) <= hs;
          SHAPE_TRIANGLE: begin
            e1  = edge_value(sx, sy, cx, cy - hh, cx - hb, cy + hh);
            e2  = edge_value(sx, sy, cx - hb, cy + hh, cx + hb, cy + hh);
            e3  = edge_value(sx, sy, cx + hb, cy + hh, cx, cy - hh);
            neg = e1 < 0 || e2 < 0 || e3 < 0;
            pos = e1 > 0 || e2 > 0 || e3 > 0;
            hit = !(neg && pos);
          end
          default: hit = 1'b0;
        endcase
        if (hit) hits++;
      end
    end
    return CountW'(hits);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [10:0] pick_coord();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 11'($urandom_range(0, 384));
    if (roll < 85) return 11'($urandom);
    case ($urandom_range(0, 3))
      0:       return 11'h400;
      1:       return 11'h3FF;
      2:       return '0;
      default: return 11'd384;
    endcase
  endfunction

  function automatic logic [7:0] pick_size();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0:       return 8'd0;
      1:       return 8'd1;
      default: return 8'd255;
    endcase
  endfunction

  task automatic wait_drain();
    while (expected_counts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SHAPE_KIND:      cfg_model.shape_kind      = val[1:0];
      REG_CENTER_X:        cfg_model.center_x        = val;
      REG_CENTER_Y:        cfg_model.center_y        = val;
      REG_RADIUS:          cfg_model.radius          = val[7:0];
      REG_HALF_SIDE:       cfg_model.half_side       = val[7:0];
      REG_TRI_HALF_BASE:   cfg_model.tri_half_base   = val[7:0];
      REG_TRI_HALF_HEIGHT: cfg_model.tri_half_height = val[7:0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the shape and size register writes carry random junk.
  task automatic load_config(input cfg_t c);
    wait_drain();
    write_reg(REG_SHAPE_KIND, {9'($urandom), c.shape_kind});
    write_reg(REG_CENTER_X, c.center_x);
    write_reg(REG_CENTER_Y, c.center_y);
    write_reg(REG_RADIUS, {3'($urandom), c.radius});
    write_reg(REG_HALF_SIDE, {3'($urandom), c.half_side});
    write_reg(REG_TRI_HALF_BASE, {3'($urandom), c.tri_half_base});
    write_reg(REG_TRI_HALF_HEIGHT, {3'($urandom), c.tri_half_height});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_burst(input pixel_t pixels[$]);
    int unsigned gap;
    foreach (pixels[n]) begin
      gap = pick_gap();
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pixels[n];
      do @(negedge clk_i); while (!s_axis_tready);
      expected_counts.push_back(predict_coverage(cfg_model, pixels[n]));
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_burst('{'{4'd0, 4'd0}, '{4'd15, 4'd15}, '{4'd8, 4'd8}, '{4'd10, 4'd5}});
  endtask

  // A centre of 7 units lands exactly on one sample of pixel (0,0).
  task automatic test_zero_size();
    cfg_t c;
    c = cfg_model;
    c.shape_kind = SHAPE_CIRCLE;
    c.center_x   = 11'sd7;
    c.center_y   = 11'sd7;
    c.radius     = 8'd0;
    load_config(c);
    send_burst('{'{4'd0, 4'd0}, '{4'd0, 4'd1}});
    c.shape_kind = SHAPE_SQUARE;
    c.half_side  = 8'd0;
    load_config(c);
    send_burst('{'{4'd0, 4'd0}, '{4'd1, 4'd1}});
  endtask

  task automatic test_triangle();
    cfg_t c;
    c = CfgReset;
    c.shape_kind = SHAPE_TRIANGLE;
    load_config(c);
    send_burst('{'{4'd8, 4'd8}, '{4'd5, 4'd8}, '{4'd11, 4'd5}});
    c.tri_half_base = 8'd0;
    load_config(c);
    send_burst('{'{4'd8, 4'd8}});
    c.tri_half_base   = 8'd96;
    c.tri_half_height = 8'd0;
    load_config(c);
    send_burst('{'{4'd8, 4'd8}});
    c.tri_half_base = 8'd0;
    load_config(c);
    send_burst('{'{4'd12, 4'd3}});
  endtask

  task automatic test_unused_kind();
    cfg_t c;
    c = CfgReset;
    c.shape_kind = ShapeUnused;
    wait_drain();
    write_reg(RegUnused, 11'($urandom));
    load_config(c);
    send_burst('{'{4'd8, 4'd8}});
  endtask

  task automatic test_extremes();
    cfg_t c;
    c.shape_kind      = SHAPE_CIRCLE;
    c.center_x        = 11'h400;
    c.center_y        = 11'h400;
    c.radius          = 8'd255;
    c.half_side       = 8'd255;
    c.tri_half_base   = 8'd255;
    c.tri_half_height = 8'd255;
    load_config(c);
    send_burst('{'{4'd0, 4'd0}});
    c.center_x = 11'h3FF;
    c.center_y = 11'h3FF;
    load_config(c);
    send_burst('{'{4'd15, 4'd15}});
    c.shape_kind = SHAPE_SQUARE;
    c.center_x   = '0;
    c.center_y   = '0;
    load_config(c);
    send_burst('{'{4'd0, 4'd0}, '{4'd15, 4'd15}, '{4'd10, 4'd10}});
  endtask

  task automatic test_random_shapes();
    cfg_t   c;
    pixel_t pixels[$];
    for (int ph = 0; ph < PhaseCount; ph++) begin
      c.shape_kind      = ($urandom_range(0, 9) == 0) ? ShapeUnused : 2'($urandom_range(0, 2));
      c.center_x        = pick_coord();
      c.center_y        = pick_coord();
      c.radius          = pick_size();
      c.half_side       = pick_size();
      c.tri_half_base   = pick_size();
      c.tri_half_height = pick_size();
      load_config(c);
      pixels.delete();
      repeat (PhaseItems) pixels.push_back(8'($urandom));
      no_gaps = (ph % 4 == 3);
      send_burst(pixels);
      no_gaps = 1'b0;
    end
  endtask

  task automatic test_output_backpressure();
    pixel_t pixels[$];
    load_config(CfgReset);
    repeat (40) pixels.push_back(8'($urandom));
    no_gaps      = 1'b1;
    hold_off_req = 1'b1;
    send_burst(pixels);
    no_gaps = 1'b0;
    wait_drain();
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LongHold;
      end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : result_check
    logic [CountW-1:0] want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_counts.size() == 0) begin
          $error("Unexpected result beat: inside_count %0d", m_axis_tdata[CountW-1:0]);
          mismatch_count++;
        end else begin
          want = expected_counts.pop_front();
          if (m_axis_tdata[CountW-1:0] !== want) begin
            $error("inside_count: expected %0d, actual %0d", want, m_axis_tdata[CountW-1:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[7] !== 1'b0) begin
            $error("pad: expected 0, actual %b", m_axis_tdata[7]);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin : test_sequence
    mismatch_count = 0;
    no_gaps        = 1'b0;
    hold_off_req   = 1'b0;
    cfg_model      = CfgReset;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_size();
    test_triangle();
    test_unused_kind();
    test_extremes();
    test_output_backpressure();
    test_random_shapes();
    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
